@@ hw/rtl/note_gate_table_defines.svh @@
// Assertion macros shared by the note gate table RTL.
// Needs clk and rst in scope where used.
`ifndef NOTE_GATE_TABLE_DEFINES_SVH
`define NOTE_GATE_TABLE_DEFINES_SVH

// condition holds every cycle out of reset
`define NGT_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define NGT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ngt_pkg.sv @@
// Types and constants for the note gate table.
// No dependencies.
`default_nettype none

package ngt_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int KIND_W = 2;
  localparam int CHAN_W = 4;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int GATE_W = 16;
  localparam int TIME_W = 32;

  typedef logic [IDX_W-1:0]  slot_idx_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [NOTE_W-1:0] note_t;
  typedef logic [VEL_W-1:0]  vel_t;
  typedef logic [GATE_W-1:0] gate_t;
  typedef logic [TIME_W-1:0] ms_t;

  localparam slot_idx_t LAST_IDX = slot_idx_t'(SLOT_COUNT - 1);
  localparam vel_t      VEL_MIN  = vel_t'(1);
  localparam gate_t     GATE_MIN = gate_t'(1);
  localparam vel_t      VEL_OFF  = '0;

  typedef enum logic [KIND_W-1:0] {
    KIND_PLAY = 2'd0,
    KIND_TICK = 2'd1,
    KIND_ALL  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLAY,
    ST_RETRIG,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic  valid;
    chan_t channel;
    note_t note;
    ms_t   deadline;
  } slot_t;

  // set: claim slot; upd: new deadline only; clr: free slot
  typedef struct packed {
    logic      set;
    logic      upd;
    logic      clr;
    slot_idx_t idx;
    chan_t     channel;
    note_t     note;
    ms_t       deadline;
  } slot_wr_t;

endpackage

`default_nettype wire

@@ hw/rtl/ngt_slots.sv @@
// Slot table: valid bits plus channel, note and deadline per slot.
// One scan read port and one write port; uses ngt_pkg.
`default_nettype none

module ngt_slots (
  input  logic              clk,
  input  logic              rst,
  input  ngt_pkg::slot_idx_t rd_idx,
  output ngt_pkg::slot_t    rd_slot,
  input  ngt_pkg::slot_wr_t wr
);
  import ngt_pkg::*;

  logic [SLOT_COUNT-1:0] valid;
  chan_t                 chan_arr [SLOT_COUNT];
  note_t                 note_arr [SLOT_COUNT];
  ms_t                   dl_arr   [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.set) begin
      valid[wr.idx] <= 1'b1;
    end else if (wr.clr) begin
      valid[wr.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set) begin
      chan_arr[wr.idx] <= wr.channel;
      note_arr[wr.idx] <= wr.note;
    end
    if (wr.set || wr.upd) begin
      dl_arr[wr.idx] <= wr.deadline;
    end
  end

  always_comb begin
    rd_slot.valid    = valid[rd_idx];
    rd_slot.channel  = chan_arr[rd_idx];
    rd_slot.note     = note_arr[rd_idx];
    rd_slot.deadline = dl_arr[rd_idx];
  end

endmodule

`default_nettype wire

@@ hw/rtl/note_gate_table.sv @@
// A play word scans every slot, then updates a matching slot or claims a free one in ST_PLAY;
// a retrigger gives a note-off in ST_RETRIG, then ST_FLUSH gives the note-on. Tick and
// release-all give note-off words during the scan and the last one in ST_FLUSH. A play with
// no match and no free slot gives no word, nor does kind 3. Words are taken only in ST_IDLE.
// Reset clears the slot valid bits, the sequencer and the output word valid.
// Uses ngt_pkg, ngt_slots and note_gate_table_defines.svh.
`default_nettype none
`include "note_gate_table_defines.svh"

module note_gate_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic [ngt_pkg::KIND_W-1:0]    kind,
  input  logic [ngt_pkg::CHAN_W-1:0]    channel,
  input  logic [ngt_pkg::NOTE_W-1:0]    note,
  input  logic [ngt_pkg::VEL_W-1:0]     velocity,
  input  logic [ngt_pkg::GATE_W-1:0]    gate_ms,
  input  logic [ngt_pkg::TIME_W-1:0]    now_ms,
  output logic                          msg_valid,
  input  logic                          msg_ready,
  output logic                          is_note_on,
  output logic [ngt_pkg::CHAN_W-1:0]    out_channel,
  output logic [ngt_pkg::NOTE_W-1:0]    out_note,
  output logic [ngt_pkg::VEL_W-1:0]     out_velocity,
  output logic                          last
);
  import ngt_pkg::*;

  state_t    state, state_next;
  slot_idx_t idx;
  logic [KIND_W-1:0] kind_r;
  chan_t     ch_r;
  note_t     note_r;
  vel_t      vel_r;
  gate_t     gate_r;
  ms_t       now_r;
  logic      hit_found, spare_found;
  slot_idx_t hit_idx, spare_idx;

  logic      pend_valid, pend_on;
  chan_t     pend_ch;
  note_t     pend_note;
  vel_t      pend_vel;

  slot_t     rd_slot;
  slot_wr_t  wr;

  logic      accept, out_free, scan_adv, due, match;
  ms_t       diff, deadline;
  logic      msg_load, msg_on_n, msg_last_n;
  chan_t     msg_ch_n;
  note_t     msg_note_n;
  vel_t      msg_vel_n;
  logic      pend_load, pend_clr, pend_on_n;
  chan_t     pend_ch_n;
  note_t     pend_note_n;
  vel_t      pend_vel_n;

  ngt_slots u_slots (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (idx),
    .rd_slot (rd_slot),
    .wr      (wr)
  );

  assign accept   = cmd_valid && cmd_ready;
  assign out_free = !msg_valid || msg_ready;

  // shared compare unit
  assign diff     = now_r - rd_slot.deadline;
  assign due      = rd_slot.valid && ((kind_r == KIND_ALL) || !diff[TIME_W-1]);
  assign match    = rd_slot.valid && (rd_slot.channel == ch_r) && (rd_slot.note == note_r);
  assign deadline = now_r + TIME_W'(gate_r);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (kind inside {KIND_PLAY, KIND_TICK, KIND_ALL})) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_adv && (idx == LAST_IDX)) begin
          state_next = (kind_r == KIND_PLAY) ? ST_PLAY : ST_FLUSH;
        end
      end
      ST_PLAY: begin
        if (hit_found) begin
          state_next = ST_RETRIG;
        end else if (spare_found) begin
          state_next = ST_FLUSH;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_RETRIG: begin
        if (out_free) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready   = 1'b0;
    scan_adv    = 1'b0;
    msg_load    = 1'b0;
    msg_on_n    = pend_on;
    msg_ch_n    = pend_ch;
    msg_note_n  = pend_note;
    msg_vel_n   = pend_vel;
    msg_last_n  = 1'b0;
    pend_load   = 1'b0;
    pend_clr    = 1'b0;
    pend_on_n   = 1'b1;
    pend_ch_n   = ch_r;
    pend_note_n = note_r;
    pend_vel_n  = vel_r;
    wr          = '0;
    wr.idx      = idx;
    wr.channel  = ch_r;
    wr.note     = note_r;
    wr.deadline = deadline;
    case (state)
      ST_IDLE: begin
        cmd_ready = 1'b1;
      end
      ST_SCAN: begin
        if (kind_r == KIND_PLAY) begin
          scan_adv = 1'b1;
        end else if (!due) begin
          scan_adv = 1'b1;
        end else if (!pend_valid || out_free) begin
          scan_adv    = 1'b1;
          pend_load   = 1'b1;
          pend_on_n   = 1'b0;
          pend_ch_n   = rd_slot.channel;
          pend_note_n = rd_slot.note;
          pend_vel_n  = VEL_OFF;
          wr.clr      = 1'b1;
          msg_load    = pend_valid;
        end
      end
      ST_PLAY: begin
        if (hit_found) begin
          wr.upd    = 1'b1;
          wr.idx    = hit_idx;
          pend_load = 1'b1;
        end else if (spare_found) begin
          wr.set    = 1'b1;
          wr.idx    = spare_idx;
          pend_load = 1'b1;
        end
      end
      ST_RETRIG: begin
        if (out_free) begin
          msg_load   = 1'b1;
          msg_on_n   = 1'b0;
          msg_ch_n   = ch_r;
          msg_note_n = note_r;
          msg_vel_n  = VEL_OFF;
        end
      end
      ST_FLUSH: begin
        if (pend_valid && out_free) begin
          msg_load   = 1'b1;
          msg_last_n = 1'b1;
          pend_clr   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx         <= '0;
      kind_r      <= kind;
      ch_r        <= channel;
      note_r      <= note;
      vel_r       <= (velocity == '0) ? VEL_MIN : velocity;
      gate_r      <= (gate_ms == '0) ? GATE_MIN : gate_ms;
      now_r       <= now_ms;
      hit_found   <= 1'b0;
      spare_found <= 1'b0;
    end else if (scan_adv) begin
      if (idx != LAST_IDX) begin
        idx <= idx + 1'b1;
      end
      if (kind_r == KIND_PLAY) begin
        if (match && !hit_found) begin
          hit_found <= 1'b1;
          hit_idx   <= idx;
        end
        if (!rd_slot.valid && !spare_found) begin
          spare_found <= 1'b1;
          spare_idx   <= idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pend_load) begin
      pend_valid <= 1'b1;
    end else if (pend_clr) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_on   <= pend_on_n;
      pend_ch   <= pend_ch_n;
      pend_note <= pend_note_n;
      pend_vel  <= pend_vel_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      msg_valid <= 1'b0;
    end else if (msg_load) begin
      msg_valid <= 1'b1;
    end else if (msg_ready) begin
      msg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_load) begin
      is_note_on   <= msg_on_n;
      out_channel  <= msg_ch_n;
      out_note     <= msg_note_n;
      out_velocity <= msg_vel_n;
      last         <= msg_last_n;
    end
  end

  `NGT_ASSERT(a_ready_no_pend, !cmd_ready || !pend_valid, "new word taken with a result pending")
  `NGT_ASSERT_IMP(a_on_is_last, msg_valid && is_note_on, last, "note-on word not marked last")
  `NGT_ASSERT_IMP(a_off_vel_zero, msg_valid && !is_note_on, out_velocity == VEL_OFF,
                  "note-off word with nonzero velocity")
  `NGT_ASSERT_IMP(a_retrig_pend, state == ST_RETRIG, pend_valid && pend_on,
                  "retrigger without a pending note-on")

endmodule

`default_nettype wire

@@ test/tb_note_gate_table.sv @@
// Self-checking testbench for note_gate_table: predicts every message word from
// its own copy of the slot table and checks the DUT output word by word.
// Depends on ngt_pkg and the note_gate_table RTL.
module tb_note_gate_table;
  timeunit 1ns;
  timeprecision 1ps;

  import ngt_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic  note_on;
    chan_t ch;
    note_t nt;
    vel_t  vel;
    logic  last_flag;
  } gate_msg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cmd_valid = 1'b0;
  logic              cmd_ready;
  logic [KIND_W-1:0] kind      = '0;
  chan_t             channel   = '0;
  note_t             note      = '0;
  vel_t              velocity  = '0;
  gate_t             gate_ms   = '0;
  ms_t               now_ms    = '0;
  logic              msg_valid;
  logic              msg_ready = 1'b0;
  logic              is_note_on;
  chan_t             out_channel;
  note_t             out_note;
  vel_t              out_velocity;
  logic              last;

  // predicted slot table
  logic  tbl_busy [SLOT_COUNT];
  chan_t tbl_ch   [SLOT_COUNT];
  note_t tbl_note [SLOT_COUNT];
  ms_t   tbl_due  [SLOT_COUNT];

  gate_msg_t owed_msgs[$];
  int        fail_count  = 0;
  bit        jitter_on   = 1'b1;
  int        rx_hold_req = 0;
  ms_t       wall_ms;

  note_gate_table dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .kind         (kind),
    .channel      (channel),
    .note         (note),
    .velocity     (velocity),
    .gate_ms      (gate_ms),
    .now_ms       (now_ms),
    .msg_valid    (msg_valid),
    .msg_ready    (msg_ready),
    .is_note_on   (is_note_on),
    .out_channel  (out_channel),
    .out_note     (out_note),
    .out_velocity (out_velocity),
    .last         (last)
  );

  always #2 clk = ~clk;

  task automatic push_msg(input logic on, input chan_t ch, input note_t nt, input vel_t vel);
    gate_msg_t m;
    m.note_on   = on;
    m.ch        = ch;
    m.nt        = nt;
    m.vel       = vel;
    m.last_flag = 1'b0;
    owed_msgs.push_back(m);
  endtask

  task automatic predict_gate_msgs(input logic [KIND_W-1:0] k, input chan_t ch,
                                   input note_t nt, input vel_t vel, input gate_t gate,
                                   input ms_t now);
    int  hit;
    int  spare;
    int  first;
    ms_t lag;
    hit   = -1;
    spare = -1;
    first = owed_msgs.size();
    case (k)
      KIND_PLAY: begin
        if (vel == '0) vel = VEL_MIN;
        if (gate == '0) gate = GATE_MIN;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (tbl_busy[i]) begin
            if (hit < 0 && tbl_ch[i] == ch && tbl_note[i] == nt) hit = i;
          end else if (spare < 0) begin
            spare = i;
          end
        end
        if (hit >= 0) begin
          tbl_due[hit] = now + ms_t'(gate);
          push_msg(1'b0, ch, nt, VEL_OFF);
        end else if (spare >= 0) begin
          tbl_busy[spare] = 1'b1;
          tbl_ch[spare]   = ch;
          tbl_note[spare] = nt;
          tbl_due[spare]  = now + ms_t'(gate);
        end
        if (hit >= 0 || spare >= 0) push_msg(1'b1, ch, nt, vel);
      end
      KIND_TICK, KIND_ALL: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!tbl_busy[i]) continue;
          lag = now - tbl_due[i];
          // far behind counts as future
          if (k == KIND_TICK && lag[TIME_W-1]) continue;
          push_msg(1'b0, tbl_ch[i], tbl_note[i], VEL_OFF);
          tbl_busy[i] = 1'b0;
        end
      end
      default: ;
    endcase
    if (owed_msgs.size() > first) owed_msgs[$].last_flag = 1'b1;
  endtask

  task automatic send_word(input logic [KIND_W-1:0] k, input chan_t ch, input note_t nt,
                           input vel_t vel, input gate_t gate, input ms_t now);
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    kind      <= k;
    channel   <= ch;
    note      <= nt;
    velocity  <= vel;
    gate_ms   <= gate;
    now_ms    <= now;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    predict_gate_msgs(k, ch, nt, vel, gate, now);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (owed_msgs.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_and_unused();
    send_word(KIND_ALL, 4'd3, 7'd9, 7'd9, 16'd9, 32'd0);
    send_word(KIND_TICK, 4'd0, 7'd0, 7'd0, 16'd0, 32'd100);
    send_word(KIND_UNUSED, 4'hF, 7'h7F, 7'h7F, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_play_edges();
    // zero velocity and zero gate are raised to one
    send_word(KIND_PLAY, 4'd0, 7'd0, 7'd0, 16'd0, 32'd0);
    // deadline wraps past 2^32
    send_word(KIND_PLAY, 4'hF, 7'h7F, 7'h7F, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(KIND_PLAY, 4'd0, 7'd0, 7'h7F, 16'd10, 32'd0);
    send_word(KIND_TICK, 4'd0, 7'd0, 7'd0, 16'd0, 32'd0);
    send_word(KIND_TICK, 4'd0, 7'd0, 7'd0, 16'd0, 32'h8001_0000);
    send_word(KIND_TICK, 4'd0, 7'd0, 7'd0, 16'd0, 32'h0000_FFFE);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < SLOT_COUNT; i++)
      send_word(KIND_PLAY, chan_t'(i), note_t'(40 + i), vel_t'(i * 8), 16'd1000, 32'd0);
    send_word(KIND_PLAY, 4'd3, 7'd99, 7'd50, 16'd5, 32'd0);
    send_word(KIND_PLAY, 4'd5, 7'd45, 7'd64, 16'd5, 32'd0);
    send_word(KIND_ALL, 4'd0, 7'd0, 7'd0, 16'd0, 32'd0);
  endtask

  task automatic test_backpressure();
    rx_hold_req = 300;
    for (int i = 0; i < 20; i++)
      send_word(KIND_PLAY, chan_t'(i % 3), note_t'(70 + i % 7), vel_t'($urandom),
                gate_t'($urandom_range(1, 50)), 32'd500);
    send_word(KIND_ALL, 4'd0, 7'd0, 7'd0, 16'd0, 32'd500);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count);
    int                done;
    int                pick;
    logic [KIND_W-1:0] k;
    chan_t             ch;
    note_t             nt;
    vel_t              vel;
    gate_t             gate;
    done = 0;
    while (done < count) begin
      ch   = chan_t'($urandom);
      nt   = note_t'($urandom);
      vel  = vel_t'($urandom);
      gate = gate_t'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        k = KIND_PLAY;
        // small pool so retriggers and a full table happen
        if ($urandom_range(0, 3) != 0) begin
          ch = chan_t'($urandom_range(0, 3));
          nt = note_t'(60 + $urandom_range(0, 3));
        end
        if ($urandom_range(0, 7) == 0) vel = '0;
        if ($urandom_range(0, 7) != 0) gate = gate_t'($urandom_range(0, 200));
      end else if (pick < 85) begin
        k = KIND_TICK;
        wall_ms += ms_t'($urandom_range(0, 150));
      end else if (pick < 92) begin
        k = KIND_ALL;
      end else if (pick < 96) begin
        k = KIND_UNUSED;
      end else begin
        k = KIND_TICK;
        if ($urandom_range(0, 1) != 0) wall_ms = $urandom;
        else wall_ms = 32'hFFFF_FFFF - ms_t'($urandom_range(0, 300));
      end
      send_word(k, ch, nt, vel, gate, wall_ms);
      if (k != KIND_UNUSED) done++;
    end
  endtask

  initial begin : rx_side
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        msg_ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        msg_ready <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(0, 2);
        msg_ready <= 1'b0;
      end else begin
        msg_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : msg_check
    gate_msg_t want;
    if (!rst && msg_valid && msg_ready) begin
      if (owed_msgs.size() == 0) begin
        $error("unexpected word: on %0d ch %0d note %0d vel %0d last %0d",
               is_note_on, out_channel, out_note, out_velocity, last);
        fail_count++;
      end else begin
        want = owed_msgs.pop_front();
        if (is_note_on !== want.note_on) begin
          $error("is_note_on: expected %0d, got %0d", want.note_on, is_note_on);
          fail_count++;
        end
        if (out_channel !== want.ch) begin
          $error("out_channel: expected %0d, got %0d", want.ch, out_channel);
          fail_count++;
        end
        if (out_note !== want.nt) begin
          $error("out_note: expected %0d, got %0d", want.nt, out_note);
          fail_count++;
        end
        if (out_velocity !== want.vel) begin
          $error("out_velocity: expected %0d, got %0d", want.vel, out_velocity);
          fail_count++;
        end
        if (last !== want.last_flag) begin
          $error("last: expected %0d, got %0d", want.last_flag, last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(2_000_000);
    $display("note_gate_table regression: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) tbl_busy[i] = 1'b0;
    wall_ms = $urandom;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_and_unused();
    test_play_edges();
    test_table_full();
    test_backpressure();
    test_random_traffic(340);
    jitter_on = 1'b0;
    test_random_traffic(60);

    wait_drained();
    repeat (3 * SLOT_COUNT) @(posedge clk);
    if (fail_count == 0) begin
      $display("note_gate_table regression: pass");
    end else begin
      $display("note_gate_table regression: fail");
    end
    $finish;
  end

endmodule
